// ===== src/kft_pkg.sv =====
// Shared types and constants for the constant-velocity Kalman tracker.
package kft_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS  = 2'd1;

    localparam logic [31:0] ACCEL_RESET = 32'd3277;
    localparam logic [31:0] MEAS_RESET  = 32'd6554;

    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_PRED = 2'd1;
    localparam logic [1:0] ACT_UPD  = 2'd2;

    typedef struct packed {
        logic        [1:0]  action;
        logic        [5:0]  track;
        logic signed [31:0] box_left;
        logic signed [31:0] box_right;
        logic signed [31:0] box_top;
        logic signed [31:0] box_bottom;
    } t_cmd;

    typedef struct packed {
        logic        [5:0]  track_out;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] var_x;
        logic signed [31:0] var_y;
        logic               singular;
        logic               saturated;
    } t_res;

endpackage

// ===== src/kft_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module kft_div #(
    parameter int NW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [31:0]     r_rem;
    logic [31:0]     r_den;
    logic [NW-1:0]   r_quo;
    logic [32:0]     trial;
    logic [32:0]     diff;
    logic            ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[31:0] : trial[31:0];
                r_quo <= {r_quo[NW-2:0], ge};
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== src/constant_velocity_kalman_tracker.sv =====
// Top level: track tables, sequencer, shared multiplier and Kalman arithmetic.
// An out-of-range track goes straight to the result strobe. An update loads
// the track, then runs 29 multiply jobs and 4 divisions, or only the
// determinant job when S is singular.
// One item at a time; busy stays high until the strobe cycle. The receiver
// cannot stall. Synchronous reset clears control, restores noise registers;
// the track tables are not cleared.
module constant_velocity_kalman_tracker
    import kft_pkg::*;
#(
    parameter int MAX_TRACKS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_cmd                 i_cmd,
    output logic                 busy,
    output logic                 o_strobe,
    output t_res                 o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int TW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int MW     = TW + 2;
    localparam int CW     = TW + 4;
    localparam int MDEPTH = 4 * MAX_TRACKS;
    localparam int CDEPTH = 16 * MAX_TRACKS;
    localparam int NW     = 32 + FRAC_BITS;

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [49:0] SMAX   = 50'sh7FFF_FFFF;
    localparam logic signed [49:0] SMIN   = -50'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_PREP, S_PRED, S_JOB, S_DIVS, S_DIVW, S_WRITE, S_OUT
    } t_state;

    typedef enum logic [1:0] {JP_DET, JP_K, JP_NP, JP_M} t_phase;

    function automatic logic [32:0] sat50(input logic signed [49:0] v);
        if (v > SMAX) return {1'b1, 32'h7FFF_FFFF};
        if (v < SMIN) return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] sqs(input logic [63:0] p, input int sh);
        logic [64:0] t;
        t = ({1'b0, p} + (65'd1 << (sh - 1))) >> sh;
        if (t > 65'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, t[31:0]};
    endfunction

    function automatic logic signed [49:0] rnd(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = (p + HALF) >>> FRAC_BITS;
        return t[49:0];
    endfunction

    t_state            r_state;
    t_phase            r_phase;
    logic [4:0]        r_cnt;
    logic [3:0]        r_jx;
    logic [1:0]        r_sub;
    logic [31:0]       r_accel;
    logic [31:0]       r_meas;
    logic              r_clip;
    logic              r_eclip;
    logic              r_sing;
    logic              r_oor;
    t_cmd              r_cmd;
    logic signed [31:0] r_cx, r_cy;
    logic signed [31:0] r_p   [16];
    logic signed [31:0] r_n   [16];
    logic signed [31:0] r_m   [4];
    logic signed [31:0] r_mn  [4];
    logic signed [31:0] r_k   [8];
    logic signed [31:0] r_inv [4];
    logic signed [31:0] r_q4, r_q3, r_q2;
    logic signed [31:0] r_s00, r_s11, r_det, r_e0, r_e1;
    logic signed [49:0] r_acc;
    logic signed [65:0] r_prod;

    // track tables
    logic signed [31:0] mem_mean [MDEPTH];
    logic signed [31:0] mem_cov  [CDEPTH];
    logic signed [31:0] r_mrd, r_crd;
    logic [TW-1:0]      tidx;
    logic [MW-1:0]      m_addr;
    logic [CW-1:0]      c_addr;
    logic               c_we, m_we;

    assign tidx   = TW'(r_cmd.track);
    assign m_addr = {tidx, r_cnt[1:0]};
    assign c_addr = {tidx, r_cnt[3:0]};
    assign c_we   = (r_state == S_WRITE);
    assign m_we   = c_we && (r_cnt < 5'd4);

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            mem_cov[c_addr] <= r_n[r_cnt[3:0]];
        end
        if (m_we) begin
            mem_mean[m_addr] <= r_mn[r_cnt[1:0]];
        end
        r_crd <= mem_cov[c_addr];
        r_mrd <= mem_mean[m_addr];
    end

    // centre of the incoming box
    logic signed [32:0] sum_x, sum_y;
    assign sum_x = 33'(i_cmd.box_left) + 33'(i_cmd.box_right);
    assign sum_y = 33'(i_cmd.box_top) + 33'(i_cmd.box_bottom);

    // noise terms, S diagonal and innovation
    logic [32:0] sq_hi, sq_mid, sq_lo, c_s00, c_s11, c_e0, c_e1;
    logic signed [31:0] nz_r2;
    always_comb begin
        sq_hi  = sqs(r_prod[63:0], FRAC_BITS + 2);
        sq_mid = sqs(r_prod[63:0], FRAC_BITS + 1);
        sq_lo  = sqs(r_prod[63:0], FRAC_BITS);
        nz_r2  = sq_lo[31:0];
        c_s00  = sat50(50'(r_p[0]) + 50'(nz_r2));
        c_s11  = sat50(50'(r_p[5]) + 50'(nz_r2));
        c_e0   = sat50(50'(r_cx) - 50'(r_m[0]));
        c_e1   = sat50(50'(r_cy) - 50'(r_m[1]));
    end

    // predict: one covariance entry per cycle
    logic [3:0]         pk;
    logic [1:0]         pi, pj;
    logic signed [49:0] pr_acc;
    logic [32:0]        pr_res, pm0, pm1;
    always_comb begin
        pk     = r_cnt[3:0];
        pi     = pk[3:2];
        pj     = pk[1:0];
        pr_acc = 50'(r_p[pk]);
        if (!pi[1]) pr_acc = pr_acc + 50'(r_p[{1'b1, pi[0], pj}]);
        if (!pj[1]) pr_acc = pr_acc + 50'(r_p[{pi, 1'b1, pj[0]}]);
        if (!pi[1] && !pj[1]) pr_acc = pr_acc + 50'(r_p[{1'b1, pi[0], 1'b1, pj[0]}]);
        if (pi == pj) begin
            pr_acc = pr_acc + (pi[1] ? 50'(r_q2) : 50'(r_q4));
        end else if ((pi ^ pj) == 2'b10) begin
            pr_acc = pr_acc + 50'(r_q3);
        end
        pr_res = sat50(pr_acc);
        pm0    = sat50(50'(r_m[0]) + 50'(r_m[2]));
        pm1    = sat50(50'(r_m[1]) + 50'(r_m[3]));
    end

    // multiply-accumulate jobs: base +/- rnd(a1*b1) +/- rnd(a2*b2)
    logic signed [31:0] j_base, j_a1, j_b1, j_a2, j_b2;
    logic               j_neg1, j_neg2;
    always_comb begin
        j_base = '0;
        j_a1   = '0;
        j_b1   = '0;
        j_a2   = '0;
        j_b2   = '0;
        j_neg1 = 1'b0;
        j_neg2 = 1'b0;
        unique case (r_phase)
            JP_DET: begin
                j_a1   = r_s00;
                j_b1   = r_s11;
                j_a2   = r_p[1];
                j_b2   = r_p[4];
                j_neg2 = 1'b1;
            end
            JP_K: begin
                j_a1 = r_p[{r_jx[2:1], 2'b00}];
                j_b1 = r_inv[{1'b0, r_jx[0]}];
                j_a2 = r_p[{r_jx[2:1], 2'b01}];
                j_b2 = r_inv[{1'b1, r_jx[0]}];
            end
            JP_NP: begin
                j_base = r_p[r_jx];
                j_a1   = r_k[{r_jx[3:2], 1'b0}];
                j_b1   = r_p[{2'b00, r_jx[1:0]}];
                j_a2   = r_k[{r_jx[3:2], 1'b1}];
                j_b2   = r_p[{2'b01, r_jx[1:0]}];
                j_neg1 = 1'b1;
                j_neg2 = 1'b1;
            end
            JP_M: begin
                j_base = r_m[r_jx[1:0]];
                j_a1   = r_k[{r_jx[1:0], 1'b0}];
                j_b1   = r_e0;
                j_a2   = r_k[{r_jx[1:0], 1'b1}];
                j_b2   = r_e1;
            end
            default: ;
        endcase
    end

    logic signed [49:0] jb_rnd, jb_acc1;
    logic [32:0]        jb_res;
    assign jb_rnd  = rnd(r_prod);
    assign jb_acc1 = 50'(j_base) + (j_neg1 ? -jb_rnd : jb_rnd);
    assign jb_res  = sat50(r_acc + (j_neg2 ? -jb_rnd : jb_rnd));

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        nz_w;
    always_comb begin
        nz_w  = (r_cmd.action == ACT_PRED) ? r_accel : r_meas;
        mul_a = 33'(j_a1);
        mul_b = 33'(j_b1);
        if (r_state == S_LOAD) begin
            mul_a = {1'b0, nz_w};
            mul_b = {1'b0, nz_w};
        end else if (r_sub != 2'd0) begin
            mul_a = 33'(j_a2);
            mul_b = 33'(j_b2);
        end
    end

    // inverse of S: adj(S) * 2^F / det
    logic signed [32:0] dv_sn, dv_nabs, dv_dsn, dv_dabs;
    logic [NW-1:0]      dv_num, dv_quot;
    logic               dv_neg, dv_done, dv_start;
    logic [32:0]        dv_res;
    logic [31:0]        dv_lo;
    always_comb begin
        case (r_jx[1:0])
            2'd0:    dv_sn = 33'(r_s11);
            2'd1:    dv_sn = -33'(r_p[1]);
            2'd2:    dv_sn = -33'(r_p[4]);
            default: dv_sn = 33'(r_s00);
        endcase
        dv_nabs = dv_sn[32] ? -dv_sn : dv_sn;
        dv_dsn  = 33'(r_det);
        dv_dabs = dv_dsn[32] ? -dv_dsn : dv_dsn;
        dv_num  = {dv_nabs[31:0], {FRAC_BITS{1'b0}}};
        dv_neg  = dv_sn[32] ^ r_det[31];
        dv_lo   = dv_quot[31:0];
        if (!dv_neg) begin
            if (dv_quot > NW'(33'h0_7FFF_FFFF)) dv_res = {1'b1, 32'h7FFF_FFFF};
            else                                dv_res = {1'b0, dv_lo};
        end else begin
            if (dv_quot > NW'(33'h0_8000_0000)) dv_res = {1'b1, 32'h8000_0000};
            else                                dv_res = {1'b0, -dv_lo};
        end
    end

    assign dv_start = (r_state == S_DIVS);

    kft_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_dabs[31:0]),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    logic [3:0] ld_idx;
    assign ld_idx = r_cnt[3:0] - 4'd1;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= JP_DET;
            r_cnt   <= '0;
            r_jx    <= '0;
            r_sub   <= '0;
            r_accel <= ACCEL_RESET;
            r_meas  <= MEAS_RESET;
            r_clip  <= 1'b0;
            r_eclip <= 1'b0;
            r_sing  <= 1'b0;
            r_oor   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ACCEL: r_accel <= i_cfg_data;
                    CFG_MEAS:  r_meas  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_cx    <= sum_x[32:1];
                        r_cy    <= sum_y[32:1];
                        r_clip  <= 1'b0;
                        r_eclip <= 1'b0;
                        r_sing  <= 1'b0;
                        r_cnt   <= '0;
                        if (int'(i_cmd.track) < MAX_TRACKS) begin
                            r_oor   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_oor   <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 5'd0) begin
                        r_p[ld_idx] <= r_crd;
                        if (ld_idx < 4'd4) r_m[ld_idx[1:0]] <= r_mrd;
                    end
                    if (r_cnt == 5'd16) r_state <= S_PREP;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_PREP: begin
                    r_cnt <= '0;
                    unique case (r_cmd.action)
                        ACT_INIT: begin
                            r_mn[0] <= r_cx;
                            r_mn[1] <= r_cy;
                            r_mn[2] <= '0;
                            r_mn[3] <= '0;
                            for (int k = 0; k < 16; k++) begin
                                r_n[k] <= (k % 5 == 0) ? ONE_FX : 32'sd0;
                            end
                            r_state <= S_WRITE;
                        end
                        ACT_PRED: begin
                            r_q4    <= sq_hi[31:0];
                            r_q3    <= sq_mid[31:0];
                            r_q2    <= sq_lo[31:0];
                            r_clip  <= sq_hi[32] | sq_mid[32] | sq_lo[32];
                            r_state <= S_PRED;
                        end
                        ACT_UPD: begin
                            r_s00   <= c_s00[31:0];
                            r_s11   <= c_s11[31:0];
                            r_e0    <= c_e0[31:0];
                            r_e1    <= c_e1[31:0];
                            r_clip  <= sq_lo[32] | c_s00[32] | c_s11[32];
                            r_eclip <= c_e0[32] | c_e1[32];
                            r_phase <= JP_DET;
                            r_jx    <= '0;
                            r_sub   <= '0;
                            r_state <= S_JOB;
                        end
                        default: begin
                            r_n     <= r_p;
                            r_mn    <= r_m;
                            r_state <= S_WRITE;
                        end
                    endcase
                end
                S_PRED: begin
                    r_n[pk] <= pr_res[31:0];
                    // mean moves with the first entry
                    r_clip  <= r_clip | pr_res[32] | ((pk == 4'd0) & (pm0[32] | pm1[32]));
                    if (pk == 4'd0) begin
                        r_mn[0] <= pm0[31:0];
                        r_mn[1] <= pm1[31:0];
                        r_mn[2] <= r_m[2];
                        r_mn[3] <= r_m[3];
                    end
                    if (pk == 4'd15) begin
                        r_cnt   <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_JOB: begin
                    case (r_sub)
                        2'd0: r_sub <= 2'd1;
                        2'd1: begin
                            r_acc <= jb_acc1;
                            r_sub <= 2'd2;
                        end
                        default: begin
                            r_sub  <= 2'd0;
                            // innovation clips count only when the update goes ahead
                            r_clip <= r_clip | jb_res[32] |
                                      ((r_phase == JP_DET) && (jb_res[31:0] != 32'd0) && r_eclip);
                            unique case (r_phase)
                                JP_DET: begin
                                    r_det <= jb_res[31:0];
                                    r_jx  <= '0;
                                    if (jb_res[31:0] == 32'd0) begin
                                        r_sing  <= 1'b1;
                                        r_n     <= r_p;
                                        r_mn    <= r_m;
                                        r_cnt   <= '0;
                                        r_state <= S_WRITE;
                                    end else begin
                                        r_state <= S_DIVS;
                                    end
                                end
                                JP_K: begin
                                    r_k[r_jx[2:0]] <= jb_res[31:0];
                                    if (r_jx == 4'd7) begin
                                        r_jx    <= '0;
                                        r_phase <= JP_NP;
                                    end else begin
                                        r_jx <= r_jx + 4'd1;
                                    end
                                end
                                JP_NP: begin
                                    r_n[r_jx] <= jb_res[31:0];
                                    if (r_jx == 4'd15) begin
                                        r_jx    <= '0;
                                        r_phase <= JP_M;
                                    end else begin
                                        r_jx <= r_jx + 4'd1;
                                    end
                                end
                                JP_M: begin
                                    r_mn[r_jx[1:0]] <= jb_res[31:0];
                                    if (r_jx == 4'd3) begin
                                        r_jx    <= '0;
                                        r_cnt   <= '0;
                                        r_state <= S_WRITE;
                                    end else begin
                                        r_jx <= r_jx + 4'd1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    endcase
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (dv_done) begin
                        r_inv[r_jx[1:0]] <= dv_res[31:0];
                        r_clip <= r_clip | dv_res[32];
                        if (r_jx == 4'd3) begin
                            r_jx    <= '0;
                            r_sub   <= '0;
                            r_phase <= JP_K;
                            r_state <= S_JOB;
                        end else begin
                            r_jx    <= r_jx + 4'd1;
                            r_state <= S_DIVS;
                        end
                    end
                end
                S_WRITE: begin
                    if (r_cnt == 5'd15) r_state <= S_OUT;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_res           = '0;
        o_res.track_out = r_cmd.track;
        if (!r_oor) begin
            o_res.pos_x     = r_mn[0];
            o_res.pos_y     = r_mn[1];
            o_res.vel_x     = r_mn[2];
            o_res.vel_y     = r_mn[3];
            o_res.var_x     = r_n[0];
            o_res.var_y     = r_n[5];
            o_res.singular  = r_sing;
            o_res.saturated = r_clip;
        end
    end

`ifndef ASSERT_OFF
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result strobe outside a busy beat");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("more than one result beat per item");
    a_idle_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !c_we) else $error("track table written while idle");
    a_sing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.singular) |-> (int'(o_res.track_out) < MAX_TRACKS))
        else $error("singular flag on an out-of-range track");
`endif

endmodule
